FILE: src/i2crw_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package i2crw_pkg;

  // Field widths
  localparam int unsigned ActionW   = 2;
  localparam int unsigned ByteW     = 8;
  localparam int unsigned DevAddrW  = 7;
  localparam int unsigned StatusW   = 2;
  localparam int unsigned BitIdxW   = 4;
  localparam int unsigned CfgIdxW   = 1;
  localparam int unsigned CfgDataW  = 8;

  // Command queue between front and back
  localparam int unsigned QDepth    = 2;
  localparam int unsigned QPtrW     = $clog2(QDepth);
  localparam int unsigned QCntW     = $clog2(QDepth + 1);

  // Action codes on the input channel
  localparam logic [ActionW-1:0] ACT_TICK  = 2'd0;
  localparam logic [ActionW-1:0] ACT_WRITE = 2'd1;
  localparam logic [ActionW-1:0] ACT_READ  = 2'd2;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] CFG_HALF_PERIOD = 1'b0;
  localparam logic [CfgIdxW-1:0] CFG_DEVICE_ADDR = 1'b1;

  // Reset values of the configuration registers
  localparam logic [ByteW-1:0]    HALF_PERIOD_RST = 8'd5;
  localparam logic [DevAddrW-1:0] DEVICE_ADDR_RST = 7'd0;

  // Status codes
  localparam logic [StatusW-1:0] ST_OK         = 2'd0;
  localparam logic [StatusW-1:0] ST_START_FAIL = 2'd1;
  localparam logic [StatusW-1:0] ST_ADDR_NACK  = 2'd2;
  localparam logic [StatusW-1:0] ST_RSTART_FAIL = 2'd3;

  // Classified command kind
  typedef enum logic [1:0] {
    CMD_TICK  = 2'd0,
    CMD_WRITE = 2'd1,
    CMD_READ  = 2'd2
  } cmd_kind_e;

  // One classified word handed from front to back
  typedef struct packed {
    cmd_kind_e        kind;
    logic [ByteW-1:0] reg_addr;
    logic [ByteW-1:0] wr_data;
    logic             sda_in;
  } cmd_t;

  // Queue status seen by the front
  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  // Bus sequencer phases
  typedef enum logic [14:0] {
    PH_IDLE      = 15'b000000000000001,
    PH_ST_HIGH   = 15'b000000000000010,
    PH_ST_LOW    = 15'b000000000000100,
    PH_TX_LOW    = 15'b000000000001000,
    PH_TX_HIGH   = 15'b000000000010000,
    PH_ACK_LOW   = 15'b000000000100000,
    PH_ACK_HIGH  = 15'b000000001000000,
    PH_RS_PREP   = 15'b000000010000000,
    PH_RX_LOW    = 15'b000000100000000,
    PH_RX_HIGH   = 15'b000001000000000,
    PH_NACK_LOW  = 15'b000010000000000,
    PH_NACK_HIGH = 15'b000100000000000,
    PH_SP_A      = 15'b001000000000000,
    PH_SP_B      = 15'b010000000000000,
    PH_SP_C      = 15'b100000000000000
  } phase_e;

  // Which byte is on the bus
  typedef enum logic [1:0] {
    STG_DEV_W = 2'd0,
    STG_REG   = 2'd1,
    STG_DATA  = 2'd2,
    STG_DEV_R = 2'd3
  } stage_e;

endpackage

`default_nettype wire

FILE: src/i2crw_if.sv
`timescale 1ns / 1ps
`default_nettype none

// Input channel: one tick word per handshake
interface i2crw_in_if;
  import i2crw_pkg::*;

  logic               valid;
  logic               ready;
  logic [ActionW-1:0] action;
  logic [ByteW-1:0]   reg_addr;
  logic [ByteW-1:0]   wr_data;
  logic               sda_in;

  modport source (output valid, action, reg_addr, wr_data, sda_in, input ready);
  modport sink   (input valid, action, reg_addr, wr_data, sda_in, output ready);
endinterface

// Result channel: one bus/status word per tick
interface i2crw_out_if;
  import i2crw_pkg::*;

  logic               valid;
  logic               ready;
  logic               scl_level;
  logic               sda_level;
  logic               busy_res;
  logic               done_res;
  logic [StatusW-1:0] status;
  logic [ByteW-1:0]   rd_data;

  modport source (output valid, scl_level, sda_level, busy_res, done_res, status, rd_data,
                  input ready);
  modport sink   (input valid, scl_level, sda_level, busy_res, done_res, status, rd_data,
                  output ready);
endinterface

// Configuration write channel
interface i2crw_cfg_if;
  import i2crw_pkg::*;

  logic                valid;
  logic                ready;
  logic [CfgIdxW-1:0]  index;
  logic [CfgDataW-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

FILE: src/i2c_register_read_write_master.sv
`timescale 1ns / 1ps
`default_nettype none

// I2C master for single-byte register writes and reads. Every input word is one
// timing tick and yields exactly one result word carrying the SCL/SDA levels,
// busy, done, status and the last read byte; action 1 or 2 on an idle tick starts
// a write or a read. One word is taken per clock cycle while the queue has room:
// the front classifies each word into a two-entry queue, and the bus sequencer in
// the back advances one tick per cycle, unless a result waits, into an output
// register; a word passes the queue entry and then the output register, and the
// input flows while a result waits until the queue fills. Configuration writes are
// taken at any time and must only be issued while no tick is in flight.
module i2c_register_read_write_master (
  input  wire        clk_i,
  input  wire        rst_ni,
  i2crw_in_if.sink   in_i,
  i2crw_out_if.source out_o,
  i2crw_cfg_if.sink  cfg_i
);
  import i2crw_pkg::*;

  q_status_t q_status;
  cmd_t      cmd_in;
  cmd_t      cmd_head;
  logic      push;
  logic      pop;

  i2crw_front u_front (
    .in_i       (in_i),
    .q_status_i (q_status),
    .push_o     (push),
    .cmd_o      (cmd_in)
  );

  i2crw_queue u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .cmd_i    (cmd_in),
    .pop_i    (pop),
    .cmd_o    (cmd_head),
    .status_o (q_status)
  );

  i2crw_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_i),
    .cmd_i       (cmd_head),
    .cmd_valid_i (~q_status.empty),
    .pop_o       (pop),
    .out_o       (out_o)
  );

endmodule

`default_nettype wire

FILE: src/i2crw_front.sv
`timescale 1ns / 1ps
`default_nettype none

module i2crw_front (
  i2crw_in_if.sink              in_i,
  input  i2crw_pkg::q_status_t  q_status_i,
  output logic                  push_o,
  output i2crw_pkg::cmd_t       cmd_o
);
  import i2crw_pkg::*;

  // Take a word whenever the queue has room
  assign in_i.ready = ~q_status_i.full;
  assign push_o     = in_i.valid & ~q_status_i.full;

  // Classify the action; the unused code counts as a plain tick
  always_comb begin
    cmd_o.reg_addr = in_i.reg_addr;
    cmd_o.wr_data  = in_i.wr_data;
    cmd_o.sda_in   = in_i.sda_in;
    case (in_i.action)
      ACT_WRITE: cmd_o.kind = CMD_WRITE;
      ACT_READ:  cmd_o.kind = CMD_READ;
      ACT_TICK:  cmd_o.kind = CMD_TICK;
      default:   cmd_o.kind = CMD_TICK;
    endcase
  end

endmodule

`default_nettype wire

FILE: src/i2crw_queue.sv
`timescale 1ns / 1ps
`default_nettype none

module i2crw_queue (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  input  i2crw_pkg::cmd_t       cmd_i,
  input  logic                  pop_i,
  output i2crw_pkg::cmd_t       cmd_o,
  output i2crw_pkg::q_status_t  status_o
);
  import i2crw_pkg::*;

  cmd_t             mem_q [QDepth];
  logic [QPtrW-1:0] wptr_q, wptr_d;
  logic [QPtrW-1:0] rptr_q, rptr_d;
  logic [QCntW-1:0] cnt_q, cnt_d;

  assign status_o.full  = (cnt_q == QCntW'(QDepth));
  assign status_o.empty = (cnt_q == '0);
  assign cmd_o          = mem_q[rptr_q];

  // Pointer and fill count
  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (push_i) begin
      wptr_d = (wptr_q == QPtrW'(QDepth - 1)) ? '0 : wptr_q + 1'b1;
    end
    if (pop_i) begin
      rptr_d = (rptr_q == QPtrW'(QDepth - 1)) ? '0 : rptr_q + 1'b1;
    end
    case ({push_i, pop_i})
      2'b10:   cnt_d = cnt_q + 1'b1;
      2'b01:   cnt_d = cnt_q - 1'b1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  // Entry storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= cmd_i;
    end
  end

endmodule

`default_nettype wire

FILE: src/i2crw_back.sv
`timescale 1ns / 1ps
`default_nettype none

module i2crw_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  i2crw_cfg_if.sink        cfg_i,
  input  i2crw_pkg::cmd_t  cmd_i,
  input  logic             cmd_valid_i,
  output logic             pop_o,
  i2crw_out_if.source      out_o
);
  import i2crw_pkg::*;

  // Configuration registers
  logic [ByteW-1:0]    half_q;
  logic [DevAddrW-1:0] dev_q;

  // Sequencer state
  phase_e              phase_q, phase_d;
  stage_e              stage_q, stage_d;
  logic [ByteW-1:0]    cnt_q, cnt_d;
  logic [BitIdxW-1:0]  bit_q, bit_d;
  logic [ByteW-1:0]    shift_q, shift_d;
  logic                is_read_q, is_read_d;
  logic [ByteW-1:0]    reg_addr_q, reg_addr_d;
  logic [ByteW-1:0]    wr_data_q, wr_data_d;
  logic [StatusW-1:0]  status_q, status_d;
  logic [ByteW-1:0]    rx_q, rx_d;

  // Output register
  logic                ovalid_q;
  logic                scl_q, scl_d;
  logic                sda_q, sda_d;
  logic                busy_q, busy_d;
  logic                done_q, done_d;

  // Working values for this tick
  logic                start;
  logic                seg_end;
  logic [ByteW-1:0]    limit;
  logic [BitIdxW-1:0]  bit_inc;
  logic [ByteW-1:0]    rx_shift;
  phase_e              ph;
  logic [ByteW-1:0]    cnt;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      half_q <= HALF_PERIOD_RST;
      dev_q  <= DEVICE_ADDR_RST;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        CFG_HALF_PERIOD: half_q <= cfg_i.data;
        CFG_DEVICE_ADDR: dev_q  <= cfg_i.data[DevAddrW-1:0];
        default:         half_q <= half_q;
      endcase
    end
  end

  // One tick is processed whenever a word waits and the output slot frees up
  assign pop_o = cmd_valid_i & (~ovalid_q | out_o.ready);

  always_comb begin
    phase_d    = phase_q;
    stage_d    = stage_q;
    cnt_d      = cnt_q;
    bit_d      = bit_q;
    shift_d    = shift_q;
    is_read_d  = is_read_q;
    reg_addr_d = reg_addr_q;
    wr_data_d  = wr_data_q;
    status_d   = status_q;
    rx_d       = rx_q;
    scl_d      = 1'b1;
    sda_d      = 1'b1;
    busy_d     = 1'b0;
    done_d     = 1'b0;

    limit    = (half_q == '0) ? ByteW'(1) : half_q;
    bit_inc  = bit_q + 1'b1;
    rx_shift = {shift_q[ByteW-2:0], cmd_i.sda_in};

    // Begin only from idle
    start = (phase_q == PH_IDLE) && (cmd_i.kind != CMD_TICK);
    if (start) begin
      is_read_d  = (cmd_i.kind == CMD_READ);
      reg_addr_d = cmd_i.reg_addr;
      wr_data_d  = cmd_i.wr_data;
      status_d   = ST_OK;
      stage_d    = STG_DEV_W;
    end
    ph  = start ? PH_ST_HIGH : phase_q;
    cnt = start ? '0 : cnt_q;
    phase_d = ph;

    seg_end = ({1'b0, cnt} + 9'd1) >= {1'b0, limit};

    if (ph != PH_IDLE) begin
      busy_d = 1'b1;

      // Line levels of the current segment
      case (ph)
        PH_ST_HIGH:  begin scl_d = 1'b1; sda_d = 1'b1;       end
        PH_ST_LOW:   begin scl_d = 1'b1; sda_d = 1'b0;       end
        PH_TX_LOW:   begin scl_d = 1'b0; sda_d = shift_q[7]; end
        PH_TX_HIGH:  begin scl_d = 1'b1; sda_d = shift_q[7]; end
        PH_ACK_HIGH,
        PH_RX_HIGH,
        PH_NACK_HIGH,
        PH_SP_C:     begin scl_d = 1'b1; sda_d = 1'b1;       end
        PH_SP_A:     begin scl_d = 1'b0; sda_d = 1'b0;       end
        PH_SP_B:     begin scl_d = 1'b1; sda_d = 1'b0;       end
        default:     begin scl_d = 1'b0; sda_d = 1'b1;       end
      endcase

      if (!seg_end) begin
        cnt_d = cnt + 1'b1;
      end else begin
        cnt_d = '0;
        // Segment transitions
        case (ph)
          PH_ST_HIGH: phase_d = PH_ST_LOW;
          PH_ST_LOW: begin
            if (cmd_i.sda_in) begin
              // Line held high: abort without a stop
              status_d = (stage_q == STG_DEV_R) ? ST_RSTART_FAIL : ST_START_FAIL;
              phase_d  = PH_IDLE;
              busy_d   = 1'b0;
              done_d   = 1'b1;
            end else begin
              shift_d = {dev_q, (stage_q == STG_DEV_R)};
              bit_d   = '0;
              phase_d = PH_TX_LOW;
            end
          end
          PH_TX_LOW: phase_d = PH_TX_HIGH;
          PH_TX_HIGH: begin
            shift_d = {shift_q[ByteW-2:0], 1'b0};
            bit_d   = bit_inc;
            phase_d = (bit_inc >= BitIdxW'(8)) ? PH_ACK_LOW : PH_TX_LOW;
          end
          PH_ACK_LOW: phase_d = PH_ACK_HIGH;
          PH_ACK_HIGH: begin
            case (stage_q)
              STG_DEV_W: begin
                if (cmd_i.sda_in) begin
                  status_d = ST_ADDR_NACK;
                  phase_d  = PH_SP_A;
                end else begin
                  stage_d = STG_REG;
                  shift_d = reg_addr_q;
                  bit_d   = '0;
                  phase_d = PH_TX_LOW;
                end
              end
              STG_REG: begin
                if (is_read_q) begin
                  stage_d = STG_DEV_R;
                  phase_d = PH_RS_PREP;
                end else begin
                  stage_d = STG_DATA;
                  shift_d = wr_data_q;
                  bit_d   = '0;
                  phase_d = PH_TX_LOW;
                end
              end
              STG_DATA: phase_d = PH_SP_A;
              default: begin
                shift_d = '0;
                bit_d   = '0;
                phase_d = PH_RX_LOW;
              end
            endcase
          end
          PH_RS_PREP: phase_d = PH_ST_HIGH;
          PH_RX_LOW:  phase_d = PH_RX_HIGH;
          PH_RX_HIGH: begin
            shift_d = rx_shift;
            bit_d   = bit_inc;
            if (bit_inc >= BitIdxW'(8)) begin
              rx_d    = rx_shift;
              phase_d = PH_NACK_LOW;
            end else begin
              phase_d = PH_RX_LOW;
            end
          end
          PH_NACK_LOW:  phase_d = PH_NACK_HIGH;
          PH_NACK_HIGH: phase_d = PH_SP_A;
          PH_SP_A:      phase_d = PH_SP_B;
          PH_SP_B:      phase_d = PH_SP_C;
          default: begin
            // End of stop: transaction complete
            phase_d = PH_IDLE;
            busy_d  = 1'b0;
            done_d  = 1'b1;
          end
        endcase
      end
    end
  end

  // Sequencer state advances once per processed tick
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_IDLE;
      stage_q    <= STG_DEV_W;
      cnt_q      <= '0;
      bit_q      <= '0;
      shift_q    <= '0;
      is_read_q  <= 1'b0;
      reg_addr_q <= '0;
      wr_data_q  <= '0;
      status_q   <= ST_OK;
      rx_q       <= '0;
    end else if (pop_o) begin
      phase_q    <= phase_d;
      stage_q    <= stage_d;
      cnt_q      <= cnt_d;
      bit_q      <= bit_d;
      shift_q    <= shift_d;
      is_read_q  <= is_read_d;
      reg_addr_q <= reg_addr_d;
      wr_data_q  <= wr_data_d;
      status_q   <= status_d;
      rx_q       <= rx_d;
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ovalid_q <= 1'b0;
    end else if (pop_o) begin
      ovalid_q <= 1'b1;
    end else if (out_o.ready) begin
      ovalid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      scl_q  <= scl_d;
      sda_q  <= sda_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  assign out_o.valid     = ovalid_q;
  assign out_o.scl_level = scl_q;
  assign out_o.sda_level = sda_q;
  assign out_o.busy_res  = busy_q;
  assign out_o.done_res  = done_q;
  assign out_o.status    = status_q;
  assign out_o.rd_data   = rx_q;

endmodule

`default_nettype wire
